>>> rtl/fira_pkg.sv
// ----------------------------------------------------------------------------
// fira_pkg
// Shared types and codes for the free index range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fira_pkg;

  localparam int unsigned RsvWidth = 17;

  localparam logic [1:0] MODE_REQUEST   = 2'd0;
  localparam logic [1:0] MODE_RETURN    = 2'd1;
  localparam logic [1:0] MODE_RESET_ALL = 2'd2;
  localparam logic [1:0] MODE_RESET_RSV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [RsvWidth-1:0] RSV_RESET = 17'h10000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] return_index;
  } in_t;

  typedef struct packed {
    logic [15:0] granted_index;
    logic        granted;
    logic [1:0]  status;
  } out_t;

  // operation broadcast to every cell in the apply cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TRIM,
    OP_POP,
    OP_SET,
    OP_EXT_PREV,
    OP_EXT_NEXT,
    OP_MERGE,
    OP_INSERT
  } op_e;

  // per-cell compare results for a return
  typedef struct packed {
    logic dup;
    logic padj;
    logic nadj;
  } flag_t;

endpackage

`default_nettype wire

>>> rtl/free_index_range_allocator_core.sv
// ----------------------------------------------------------------------------
// free_index_range_allocator_core
// Index allocator built on a sorted chain of free-range cells.
// ----------------------------------------------------------------------------
// The free ranges sit in a chain of MAX_RANGES cells, highest range in the
// first cell, so a request always works on that cell. Every item passes
// through an evaluate state, in which all cells compare the returned index
// against their range at once, and an apply state, in which they shift,
// merge or rewrite from their neighbours and the result is loaded into the
// output register. A new item can be taken in the apply state of the
// previous one while the output is not stalled. The reserve register is
// 17 bits wide and is written through the cfg channel.
`default_nettype none

module free_index_range_allocator_core #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  fira_pkg::in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output fira_pkg::out_t                       out_data_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [fira_pkg::RsvWidth-1:0]        cfg_data_i
);

  localparam logic [32:0] IDX_MAX  = (33'd1 << INDEX_BITS) - 33'd1;
  localparam logic [INDEX_BITS-1:0] HEAD_END =
    INDEX_BITS'((IDX_MAX < 33'd65535) ? IDX_MAX : 33'd65535);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]                      state_q, state_d;
  fira_pkg::in_t                   in_q;
  logic                            out_valid_q;
  fira_pkg::out_t                  out_q, res;
  logic [fira_pkg::RsvWidth-1:0]   rsv_q;
  logic                            accept, apply_go, eval;
  fira_pkg::op_e                   op, op_sel;
  logic [INDEX_BITS-1:0]           idx, set_end, rsv_end;
  logic [fira_pkg::RsvWidth-1:0]   rsv_m1;
  logic [32:0]                     rsv_m1_w;

  logic [MAX_RANGES-1:0]           valid_v, above_v, dup_v, padj_v, nadj_v;
  logic [INDEX_BITS-1:0]           start_v [MAX_RANGES];
  logic [INDEX_BITS-1:0]           end_v   [MAX_RANGES];
  fira_pkg::flag_t                 flag_v  [MAX_RANGES];
  logic                            dup, padj, nadj, full;

  // ---- configuration ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q <= fira_pkg::RSV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rsv_q <= cfg_data_i;
    end
  end

  // zero acts as one; saturate to the index space
  assign rsv_m1   = (rsv_q == '0) ? '0 : rsv_q - {{(fira_pkg::RsvWidth-1){1'b0}}, 1'b1};
  assign rsv_m1_w = 33'(rsv_m1);
  assign rsv_end  = INDEX_BITS'((rsv_m1_w > IDX_MAX) ? IDX_MAX : rsv_m1_w);

  // ---- sequencing ----
  assign apply_go   = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || apply_go);
  assign accept     = in_valid_i && !in_stall_o;
  assign eval       = (state_q == S_EVAL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: if (apply_go) state_d = accept ? S_EVAL : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (apply_go) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx = INDEX_BITS'(in_q.return_index);

  // ---- decision ----
  assign dup  = |dup_v;
  assign padj = |padj_v;
  assign nadj = |nadj_v;
  assign full = valid_v[MAX_RANGES-1];

  always_comb begin
    op_sel            = fira_pkg::OP_NONE;
    set_end           = rsv_end;
    res.granted_index = '0;
    res.granted       = 1'b0;
    res.status        = fira_pkg::ST_OK;
    case (in_q.mode)
      fira_pkg::MODE_REQUEST: begin
        if (!valid_v[0]) begin
          res.status = fira_pkg::ST_EMPTY;
        end else begin
          res.granted       = 1'b1;
          res.granted_index = 16'(32'(end_v[0]));
          op_sel = (start_v[0] == end_v[0]) ? fira_pkg::OP_POP : fira_pkg::OP_TRIM;
        end
      end
      fira_pkg::MODE_RETURN: begin
        if (dup) begin
          res.status = fira_pkg::ST_DUP;
        end else if (padj && nadj) begin
          op_sel = fira_pkg::OP_MERGE;
        end else if (padj) begin
          op_sel = fira_pkg::OP_EXT_PREV;
        end else if (nadj) begin
          op_sel = fira_pkg::OP_EXT_NEXT;
        end else if (full) begin
          res.status = fira_pkg::ST_FULL;
        end else begin
          op_sel = fira_pkg::OP_INSERT;
        end
      end
      fira_pkg::MODE_RESET_ALL: begin
        // first cell holds the highest range, hence the largest end
        op_sel  = fira_pkg::OP_SET;
        set_end = valid_v[0] ? end_v[0] : '0;
      end
      default: begin
        op_sel  = fira_pkg::OP_SET;
        set_end = rsv_end;
      end
    endcase
  end

  assign op = apply_go ? op_sel : fira_pkg::OP_NONE;

  // ---- cell chain ----
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic                  up_valid, dn_valid, above_up, above_dn;
    logic [INDEX_BITS-1:0] up_start, up_end, dn_start, dn_end;

    if (i == MAX_RANGES - 1) begin : g_tail
      assign up_valid = 1'b0;
      assign up_start = '0;
      assign up_end   = '0;
      assign above_up = 1'b0;
    end else begin : g_mid_up
      assign up_valid = valid_v[i+1];
      assign up_start = start_v[i+1];
      assign up_end   = end_v[i+1];
      assign above_up = above_v[i+1];
    end

    if (i == 0) begin : g_head
      assign dn_valid = 1'b0;
      assign dn_start = '0;
      assign dn_end   = '0;
      assign above_dn = 1'b1;
    end else begin : g_mid_dn
      assign dn_valid = valid_v[i-1];
      assign dn_start = start_v[i-1];
      assign dn_end   = end_v[i-1];
      assign above_dn = above_v[i-1];
    end

    fira_cell #(
      .INDEX_BITS (INDEX_BITS),
      .IS_HEAD    (i == 0),
      .HEAD_END   (HEAD_END)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .eval_i     (eval),
      .op_i       (op),
      .idx_i      (idx),
      .set_end_i  (set_end),
      .up_valid_i (up_valid),
      .up_start_i (up_start),
      .up_end_i   (up_end),
      .above_up_i (above_up),
      .dn_valid_i (dn_valid),
      .dn_start_i (dn_start),
      .dn_end_i   (dn_end),
      .above_dn_i (above_dn),
      .above_o    (above_v[i]),
      .valid_o    (valid_v[i]),
      .start_o    (start_v[i]),
      .end_o      (end_v[i]),
      .flag_o     (flag_v[i])
    );

    assign dup_v[i]  = flag_v[i].dup;
    assign padj_v[i] = flag_v[i].padj;
    assign nadj_v[i] = flag_v[i].nadj;
  end

endmodule

`default_nettype wire

>>> rtl/fira_cell.sv
// ----------------------------------------------------------------------------
// fira_cell
// One free range of the chain: compares against the returned index and
// shifts, merges or rewrites itself from its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module fira_cell #(
  parameter int unsigned INDEX_BITS = 16,
  parameter bit          IS_HEAD    = 1'b0,
  parameter logic [INDEX_BITS-1:0] HEAD_END = '1
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     eval_i,
  input  wire  fira_pkg::op_e     op_i,
  input  wire  [INDEX_BITS-1:0]   idx_i,
  input  wire  [INDEX_BITS-1:0]   set_end_i,
  // neighbour holding the next lower range
  input  wire                     up_valid_i,
  input  wire  [INDEX_BITS-1:0]   up_start_i,
  input  wire  [INDEX_BITS-1:0]   up_end_i,
  input  wire                     above_up_i,
  // neighbour holding the next higher range
  input  wire                     dn_valid_i,
  input  wire  [INDEX_BITS-1:0]   dn_start_i,
  input  wire  [INDEX_BITS-1:0]   dn_end_i,
  input  wire                     above_dn_i,
  output logic                    above_o,
  output logic                    valid_o,
  output logic [INDEX_BITS-1:0]   start_o,
  output logic [INDEX_BITS-1:0]   end_o,
  output fira_pkg::flag_t         flag_o
);

  logic                  valid_q, valid_d;
  logic [INDEX_BITS-1:0] start_q, start_d;
  logic [INDEX_BITS-1:0] end_q, end_d;
  logic                  above_q, at_pos_q, prev_q, next_q;
  logic                  at_pos, prev_c, next_c;
  fira_pkg::flag_t       flag_q, flag_c;

  assign above_o = valid_q && (start_q > idx_i);
  assign at_pos  = !above_o && above_dn_i;
  assign prev_c  = at_pos && valid_q;
  assign next_c  = above_o && !above_up_i;

  always_comb begin
    flag_c.dup  = prev_c && (end_q >= idx_i);
    flag_c.padj = prev_c &&
                  (({1'b0, end_q} + {{INDEX_BITS{1'b0}}, 1'b1}) == {1'b0, idx_i});
    flag_c.nadj = next_c &&
                  ({1'b0, start_q} == ({1'b0, idx_i} + {{INDEX_BITS{1'b0}}, 1'b1}));
  end

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    end_d   = end_q;
    case (op_i)
      fira_pkg::OP_TRIM: begin
        if (IS_HEAD) end_d = end_q - {{(INDEX_BITS-1){1'b0}}, 1'b1};
      end
      fira_pkg::OP_POP: begin
        valid_d = up_valid_i;
        start_d = up_start_i;
        end_d   = up_end_i;
      end
      fira_pkg::OP_SET: begin
        if (IS_HEAD) begin
          valid_d = 1'b1;
          start_d = '0;
          end_d   = set_end_i;
        end else begin
          valid_d = 1'b0;
        end
      end
      fira_pkg::OP_EXT_PREV: begin
        if (prev_q) end_d = idx_i;
      end
      fira_pkg::OP_EXT_NEXT: begin
        if (next_q) start_d = idx_i;
      end
      fira_pkg::OP_MERGE: begin
        // next range absorbs the previous one; everything below closes up
        if (next_q) begin
          start_d = up_start_i;
        end else if (!above_q) begin
          valid_d = up_valid_i;
          start_d = up_start_i;
          end_d   = up_end_i;
        end
      end
      fira_pkg::OP_INSERT: begin
        if (at_pos_q) begin
          valid_d = 1'b1;
          start_d = idx_i;
          end_d   = idx_i;
        end else if (!above_q) begin
          valid_d = dn_valid_i;
          start_d = dn_start_i;
          end_d   = dn_end_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= IS_HEAD;
      start_q <= '0;
      end_q   <= IS_HEAD ? HEAD_END : '0;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_i) begin
      above_q  <= above_o;
      at_pos_q <= at_pos;
      prev_q   <= prev_c;
      next_q   <= next_c;
      flag_q   <= flag_c;
    end
  end

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign end_o   = end_q;
  assign flag_o  = flag_q;

endmodule

`default_nettype wire
